// ----- rtl/core/bfi_pkg.sv -----
package bfi_pkg;

    // Store sizes and the address widths that follow from them.
    localparam int PROGRAM_DEPTH = 1024;
    localparam int TAPE_DEPTH    = 4096;
    localparam int PA_W          = $clog2(PROGRAM_DEPTH);
    localparam int PC_W          = $clog2(PROGRAM_DEPTH + 1);
    localparam int TA_W          = $clog2(TAPE_DEPTH);

    localparam logic [TA_W-1:0] TAPE_LAST   = TA_W'(TAPE_DEPTH - 1);
    localparam logic [PC_W-1:0] PROGRAM_MAX = PC_W'(PROGRAM_DEPTH);

    // Stream payload widths.
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 5;

    // Command characters.
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    typedef enum logic [1:0] {
        CMD_APPEND     = 2'd0,
        CMD_EXECUTE    = 2'd1,
        CMD_RESTART    = 2'd2,
        CMD_CLEAR_PROG = 2'd3
    } cmd_t;

    // Datapath operation requested by the controller in each cycle.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_APPEND,
        DP_CLEAR_PROG,
        DP_RESTART,
        DP_CLEAR_STEP,
        DP_FETCH,
        DP_EXECUTE,
        DP_SCAN_F_START,
        DP_SCAN_B_START,
        DP_SCAN_READ,
        DP_SCAN_CHECK,
        DP_FAIL,
        DP_RESULT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_RST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_RESTART_CLEAR,
        ST_DECODE,
        ST_SCAN_ISSUE,
        ST_SCAN_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t command;
        logic halted;
        logic op_open;
        logic op_close;
        logic cell_zero;
        logic scan_end;
        logic scan_hit;
        logic clr_last;
        logic out_busy;
    } status_t;

endpackage

// ----- rtl/core/bfi_ctrl.sv -----
// Sequencer for the interpreter: decides which datapath operation runs in each cycle.
module bfi_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  bfi_pkg::status_t   status,
    output bfi_pkg::dp_op_t    op
);

    bfi_pkg::state_t state_reg;
    bfi_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfi_pkg::ST_RST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfi_pkg::ST_RST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = bfi_pkg::ST_IDLE;
                end
            end
            bfi_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = bfi_pkg::ST_DISPATCH;
                end
            end
            bfi_pkg::ST_DISPATCH:
            begin
                unique case (status.command)
                    bfi_pkg::CMD_RESTART:
                    begin
                        state_next = bfi_pkg::ST_RESTART_CLEAR;
                    end
                    bfi_pkg::CMD_EXECUTE:
                    begin
                        state_next = status.halted ? bfi_pkg::ST_DONE : bfi_pkg::ST_DECODE;
                    end
                    default:
                    begin
                        state_next = bfi_pkg::ST_DONE;
                    end
                endcase
            end
            bfi_pkg::ST_RESTART_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = bfi_pkg::ST_DONE;
                end
            end
            bfi_pkg::ST_DECODE:
            begin
                if ((status.op_open && status.cell_zero) ||
                    (status.op_close && !status.cell_zero))
                begin
                    state_next = bfi_pkg::ST_SCAN_ISSUE;
                end
                else
                begin
                    state_next = bfi_pkg::ST_DONE;
                end
            end
            bfi_pkg::ST_SCAN_ISSUE:
            begin
                state_next = status.scan_end ? bfi_pkg::ST_DONE : bfi_pkg::ST_SCAN_CHECK;
            end
            bfi_pkg::ST_SCAN_CHECK:
            begin
                state_next = status.scan_hit ? bfi_pkg::ST_DONE : bfi_pkg::ST_SCAN_ISSUE;
            end
            bfi_pkg::ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = bfi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op       = bfi_pkg::DP_NOP;
        s_tready = 1'b0;
        unique case (state_reg)
            bfi_pkg::ST_RST_CLEAR,
            bfi_pkg::ST_RESTART_CLEAR:
            begin
                op = bfi_pkg::DP_CLEAR_STEP;
            end
            bfi_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op = bfi_pkg::DP_CAPTURE;
                end
            end
            bfi_pkg::ST_DISPATCH:
            begin
                unique case (status.command)
                    bfi_pkg::CMD_APPEND:     op = bfi_pkg::DP_APPEND;
                    bfi_pkg::CMD_CLEAR_PROG: op = bfi_pkg::DP_CLEAR_PROG;
                    bfi_pkg::CMD_RESTART:    op = bfi_pkg::DP_RESTART;
                    bfi_pkg::CMD_EXECUTE:
                    begin
                        op = status.halted ? bfi_pkg::DP_NOP : bfi_pkg::DP_FETCH;
                    end
                    default:                 op = bfi_pkg::DP_NOP;
                endcase
            end
            bfi_pkg::ST_DECODE:
            begin
                priority if (status.op_open && status.cell_zero)
                begin
                    op = bfi_pkg::DP_SCAN_F_START;
                end
                else if (status.op_close && !status.cell_zero)
                begin
                    op = bfi_pkg::DP_SCAN_B_START;
                end
                else
                begin
                    op = bfi_pkg::DP_EXECUTE;
                end
            end
            bfi_pkg::ST_SCAN_ISSUE:
            begin
                op = status.scan_end ? bfi_pkg::DP_FAIL : bfi_pkg::DP_SCAN_READ;
            end
            bfi_pkg::ST_SCAN_CHECK:
            begin
                op = bfi_pkg::DP_SCAN_CHECK;
            end
            bfi_pkg::ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    op = bfi_pkg::DP_RESULT;
                end
            end
            default:
            begin
                op = bfi_pkg::DP_NOP;
            end
        endcase
    end

endmodule

// ----- rtl/core/bfi_datapath.sv -----
// Program store, tape, machine registers and the result register.
module bfi_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfi_pkg::dp_op_t               op,
    output bfi_pkg::status_t              status,
    input  logic [bfi_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [bfi_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bfi_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [bfi_pkg::M_USER_W-1:0]  m_tuser
);

    localparam int PA_W = bfi_pkg::PA_W;
    localparam int PC_W = bfi_pkg::PC_W;
    localparam int TA_W = bfi_pkg::TA_W;

    logic [7:0] prog_mem [bfi_pkg::PROGRAM_DEPTH];
    logic [7:0] tape_mem [bfi_pkg::TAPE_DEPTH];

    // Machine state.
    logic [PC_W-1:0] len_reg, len_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [TA_W-1:0] dp_reg, dp_next;
    logic            err_reg, err_next;
    logic [TA_W-1:0] clr_reg, clr_next;
    logic            m_tvalid_reg, m_tvalid_next;

    // Item and scan working registers.
    bfi_pkg::cmd_t   cmd_reg, cmd_next;
    logic [7:0]      data_reg, data_next;
    logic [PC_W-1:0] scan_reg, scan_next;
    logic [PC_W-1:0] depth_reg, depth_next;
    logic            fwd_reg, fwd_next;
    logic            res_out_valid_reg, res_out_valid_next;
    logic [7:0]      res_out_byte_reg, res_out_byte_next;
    logic            res_input_used_reg, res_input_used_next;
    logic            res_bracket_error_reg, res_bracket_error_next;
    logic            res_append_full_reg, res_append_full_next;
    logic [bfi_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [bfi_pkg::M_USER_W-1:0] m_tuser_reg, m_tuser_next;

    // Memory ports.
    logic [7:0]      prog_rdata_reg;
    logic [7:0]      tape_rdata_reg;
    logic [PA_W-1:0] prog_raddr;
    logic            prog_we;
    logic [TA_W-1:0] tape_addr;
    logic            tape_we;
    logic [7:0]      tape_wdata;

    logic [PC_W-1:0] scan_m1;
    logic [7:0]      near_ch;
    logic [7:0]      far_ch;
    logic            halted;
    logic            scan_hit;

    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem[len_reg[PA_W-1:0]] <= data_reg;
        end
        prog_rdata_reg <= prog_mem[prog_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_addr] <= tape_wdata;
        end
        tape_rdata_reg <= tape_mem[tape_addr];
    end

    assign scan_m1  = scan_reg - PC_W'(1);
    assign near_ch  = fwd_reg ? bfi_pkg::CH_OPEN : bfi_pkg::CH_CLOSE;
    assign far_ch   = fwd_reg ? bfi_pkg::CH_CLOSE : bfi_pkg::CH_OPEN;
    assign halted   = err_reg || (pc_reg >= len_reg);
    assign scan_hit = (prog_rdata_reg == far_ch) && (depth_reg == PC_W'(1));

    always_comb
    begin
        status.command   = cmd_reg;
        status.halted    = halted;
        status.op_open   = (prog_rdata_reg == bfi_pkg::CH_OPEN);
        status.op_close  = (prog_rdata_reg == bfi_pkg::CH_CLOSE);
        status.cell_zero = (tape_rdata_reg == 8'd0);
        status.scan_end  = fwd_reg ? (scan_reg >= len_reg) : (scan_reg == '0);
        status.scan_hit  = scan_hit;
        status.clr_last  = (clr_reg == bfi_pkg::TAPE_LAST);
        status.out_busy  = m_tvalid_reg && !m_tready;
    end

    always_comb
    begin
        len_next               = len_reg;
        pc_next                = pc_reg;
        dp_next                = dp_reg;
        err_next               = err_reg;
        clr_next               = clr_reg;
        m_tvalid_next          = m_tvalid_reg && !m_tready;
        cmd_next               = cmd_reg;
        data_next              = data_reg;
        scan_next              = scan_reg;
        depth_next             = depth_reg;
        fwd_next               = fwd_reg;
        res_out_valid_next     = res_out_valid_reg;
        res_out_byte_next      = res_out_byte_reg;
        res_input_used_next    = res_input_used_reg;
        res_bracket_error_next = res_bracket_error_reg;
        res_append_full_next   = res_append_full_reg;
        m_tdata_next           = m_tdata_reg;
        m_tuser_next           = m_tuser_reg;
        prog_raddr             = pc_reg[PA_W-1:0];
        prog_we                = 1'b0;
        tape_addr              = dp_reg;
        tape_we                = 1'b0;
        tape_wdata             = 8'd0;

        unique case (op)
            bfi_pkg::DP_NOP,
            bfi_pkg::DP_FETCH:
            begin
            end
            bfi_pkg::DP_CAPTURE:
            begin
                cmd_next               = bfi_pkg::cmd_t'(s_tuser);
                data_next              = s_tdata;
                res_out_valid_next     = 1'b0;
                res_out_byte_next      = 8'd0;
                res_input_used_next    = 1'b0;
                res_bracket_error_next = 1'b0;
                res_append_full_next   = 1'b0;
            end
            bfi_pkg::DP_APPEND:
            begin
                if (len_reg == bfi_pkg::PROGRAM_MAX)
                begin
                    res_append_full_next = 1'b1;
                end
                else
                begin
                    prog_we  = 1'b1;
                    len_next = len_reg + PC_W'(1);
                end
            end
            bfi_pkg::DP_CLEAR_PROG:
            begin
                len_next = '0;
                pc_next  = '0;
                err_next = 1'b0;
            end
            bfi_pkg::DP_RESTART:
            begin
                dp_next  = '0;
                pc_next  = '0;
                err_next = 1'b0;
                clr_next = '0;
            end
            bfi_pkg::DP_CLEAR_STEP:
            begin
                tape_we   = 1'b1;
                tape_addr = clr_reg;
                clr_next  = (clr_reg == bfi_pkg::TAPE_LAST) ? '0 : clr_reg + TA_W'(1);
            end
            bfi_pkg::DP_EXECUTE:
            begin
                pc_next = pc_reg + PC_W'(1);
                unique case (prog_rdata_reg)
                    bfi_pkg::CH_RIGHT:
                    begin
                        dp_next = (dp_reg == bfi_pkg::TAPE_LAST) ? '0 : dp_reg + TA_W'(1);
                    end
                    bfi_pkg::CH_LEFT:
                    begin
                        dp_next = (dp_reg == '0) ? bfi_pkg::TAPE_LAST : dp_reg - TA_W'(1);
                    end
                    bfi_pkg::CH_INC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata_reg + 8'd1;
                    end
                    bfi_pkg::CH_DEC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata_reg - 8'd1;
                    end
                    bfi_pkg::CH_OUT:
                    begin
                        res_out_valid_next = 1'b1;
                        res_out_byte_next  = tape_rdata_reg;
                    end
                    bfi_pkg::CH_IN:
                    begin
                        tape_we             = 1'b1;
                        tape_wdata          = data_reg;
                        res_input_used_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            bfi_pkg::DP_SCAN_F_START:
            begin
                fwd_next   = 1'b1;
                scan_next  = pc_reg + PC_W'(1);
                depth_next = PC_W'(1);
            end
            bfi_pkg::DP_SCAN_B_START:
            begin
                fwd_next   = 1'b0;
                scan_next  = pc_reg;
                depth_next = PC_W'(1);
            end
            bfi_pkg::DP_SCAN_READ:
            begin
                // A backward scan steps down before reading, a forward one after checking.
                if (fwd_reg)
                begin
                    prog_raddr = scan_reg[PA_W-1:0];
                end
                else
                begin
                    prog_raddr = scan_m1[PA_W-1:0];
                    scan_next  = scan_m1;
                end
            end
            bfi_pkg::DP_SCAN_CHECK:
            begin
                if (scan_hit)
                begin
                    pc_next = scan_reg + PC_W'(1);
                end
                else
                begin
                    if (prog_rdata_reg == near_ch)
                    begin
                        depth_next = depth_reg + PC_W'(1);
                    end
                    else if (prog_rdata_reg == far_ch)
                    begin
                        depth_next = depth_reg - PC_W'(1);
                    end
                    if (fwd_reg)
                    begin
                        scan_next = scan_reg + PC_W'(1);
                    end
                end
            end
            bfi_pkg::DP_FAIL:
            begin
                err_next               = 1'b1;
                res_bracket_error_next = 1'b1;
            end
            bfi_pkg::DP_RESULT:
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {(bfi_pkg::M_DATA_W - 8 - PC_W)'(0), pc_reg, res_out_byte_reg};
                m_tuser_next  = {res_append_full_reg, res_bracket_error_reg, halted,
                                 res_input_used_reg, res_out_valid_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            pc_reg       <= '0;
            dp_reg       <= '0;
            err_reg      <= 1'b0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            pc_reg       <= pc_next;
            dp_reg       <= dp_next;
            err_reg      <= err_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg               <= cmd_next;
        data_reg              <= data_next;
        scan_reg              <= scan_next;
        depth_reg             <= depth_next;
        fwd_reg               <= fwd_next;
        res_out_valid_reg     <= res_out_valid_next;
        res_out_byte_reg      <= res_out_byte_next;
        res_input_used_reg    <= res_input_used_next;
        res_bracket_error_reg <= res_bracket_error_next;
        res_append_full_reg   <= res_append_full_next;
        m_tdata_reg           <= m_tdata_next;
        m_tuser_reg           <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/core/brainfuck_interpreter_core.sv -----
// Brainfuck interpreter core. Each input item carries a command in s_tuser and a byte in
// s_tdata: append the byte to the program store (1024 characters), execute the instruction
// at the program counter (a ',' stores the byte into the current cell), restart with a
// cleared 4096-cell tape, or clear the program. Every item returns exactly one result item.
// Executing an ordinary instruction waits for the registered reads of the program store
// and the tape before the tape's read-modify-write. A bracket jump walks the program store
// one character per pass through the scan issue and scan check states; an unmatched
// bracket sets a sticky error that halts execution until a restart or program clear.
// The tape is cleared by a pass over all its cells, one cell per cycle: once after reset,
// during which no item is accepted, and again for every restart item, whose result follows
// the pass. A new item is accepted while the previous result is still waiting in the
// output register.
module brainfuck_interpreter_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] command

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [18:8] program_counter, [23:19] zero
    output logic [4:0]  m_tuser    // [0] out_valid, [1] input_used, [2] halted,
                                   // [3] bracket_error, [4] append_full
);

    // The controller sequences each item; the datapath holds the stores and the registers.
    bfi_pkg::dp_op_t  op;
    bfi_pkg::status_t status;

    bfi_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    // The datapath also owns the output register, so a finished result can wait there
    // while the controller takes the next item.
    bfi_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- sim/brainfuck_interpreter_core_tb.sv -----
`timescale 1ns / 1ps

module brainfuck_interpreter_core_tb;

    // The longest stretch without any handshake is a tape clearing pass over the whole tape,
    // or a bracket walk over the whole program store, plus one stall burst.
    // The limit below leaves several times that.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 525;
    localparam int DRAIN_CYCLES   = 20;

    // One result item, the first field in the highest bits so that it can be built
    // straight from a concatenation of the port fields.
    typedef struct packed {
        logic                    out_valid;
        logic [7:0]              out_byte;
        logic                    input_used;
        logic                    halted;
        logic                    bracket_error;
        logic                    append_full;
        logic [bfi_pkg::PC_W-1:0] program_counter;
    } reply_t;

    typedef logic [7:0] char_q_t [$];

    // Shadow copy of the interpreter. Every accepted item is applied to it at once, and
    // the reply it would give is queued until the block's own reply arrives.
    class interp_scoreboard;
        bit [7:0]    program_mem [bfi_pkg::PROGRAM_DEPTH];
        bit [7:0]    tape [bfi_pkg::TAPE_DEPTH];
        int unsigned prog_len;
        int unsigned pc;
        int unsigned dp;
        bit          err;
        reply_t      pending_replies [$];
        int          mismatches;

        function bit halted();
            return err || pc >= prog_len;
        endfunction

        function void apply_command(bfi_pkg::cmd_t cmd, logic [7:0] data);
            reply_t      r;
            int unsigned next_pc;
            int unsigned k;
            int unsigned depth;
            bit          found;
            bit          fwd;
            logic [7:0]  op;
            logic [7:0]  partner;
            r = '0;
            case (cmd)
                bfi_pkg::CMD_APPEND:
                begin
                    if (prog_len < bfi_pkg::PROGRAM_DEPTH)
                    begin
                        program_mem[prog_len] = data;
                        prog_len++;
                    end
                    else
                        r.append_full = 1'b1;
                end
                bfi_pkg::CMD_EXECUTE:
                begin
                    if (!halted())
                    begin
                        op      = program_mem[pc];
                        next_pc = pc + 1;
                        case (op)
                            bfi_pkg::CH_RIGHT: dp = (dp + 1) % bfi_pkg::TAPE_DEPTH;
                            bfi_pkg::CH_LEFT:
                                dp = (dp + bfi_pkg::TAPE_DEPTH - 1) % bfi_pkg::TAPE_DEPTH;
                            bfi_pkg::CH_INC:   tape[dp] = tape[dp] + 8'd1;
                            bfi_pkg::CH_DEC:   tape[dp] = tape[dp] - 8'd1;
                            bfi_pkg::CH_OUT:
                            begin
                                r.out_valid = 1'b1;
                                r.out_byte  = tape[dp];
                            end
                            bfi_pkg::CH_IN:
                            begin
                                tape[dp]     = data;
                                r.input_used = 1'b1;
                            end
                            bfi_pkg::CH_OPEN, bfi_pkg::CH_CLOSE:
                            begin
                                // An opening bracket jumps on a zero cell, a closing one on
                                // a nonzero cell. Both walk the store counting nesting.
                                fwd = (op == bfi_pkg::CH_OPEN);
                                if (fwd == (tape[dp] == 8'd0))
                                begin
                                    partner = fwd ? bfi_pkg::CH_CLOSE : bfi_pkg::CH_OPEN;
                                    depth   = 1;
                                    found   = 1'b0;
                                    k       = pc;
                                    while (!found && (fwd ? k + 1 < prog_len : k > 0))
                                    begin
                                        k = fwd ? k + 1 : k - 1;
                                        if (program_mem[k] == op)
                                            depth++;
                                        else if (program_mem[k] == partner)
                                        begin
                                            depth--;
                                            found = (depth == 0);
                                        end
                                    end
                                    if (found)
                                        next_pc = k + 1;
                                    else
                                    begin
                                        err             = 1'b1;
                                        r.bracket_error = 1'b1;
                                        next_pc         = pc;
                                    end
                                end
                            end
                            default: ;
                        endcase
                        pc = next_pc;
                    end
                end
                bfi_pkg::CMD_RESTART:
                begin
                    foreach (tape[i])
                        tape[i] = '0;
                    dp  = 0;
                    pc  = 0;
                    err = 1'b0;
                end
                default:
                begin
                    prog_len = 0;
                    pc       = 0;
                    err      = 1'b0;
                end
            endcase
            r.halted          = halted();
            r.program_counter = pc[bfi_pkg::PC_W-1:0];
            pending_replies.push_back(r);
        endfunction

        function void note_field(string name, logic [10:0] want, logic [10:0] got);
            if (want !== got)
            begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t ns: result item with none pending, expected none, actual %h",
                         $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_replies.pop_front();
                note_field("out_valid", 11'(want.out_valid), 11'(got.out_valid));
                note_field("out_byte", 11'(want.out_byte), 11'(got.out_byte));
                note_field("input_used", 11'(want.input_used), 11'(got.input_used));
                note_field("halted", 11'(want.halted), 11'(got.halted));
                note_field("bracket_error", 11'(want.bracket_error), 11'(got.bracket_error));
                note_field("append_full", 11'(want.append_full), 11'(got.append_full));
                note_field("program_counter", want.program_counter, got.program_counter);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] data_byte
    logic [1:0]  s_tuser;     // [1:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // [7:0] out_byte, [18:8] program_counter, [23:19] zero
    logic [4:0]  m_tuser;     // [0] out_valid, [1] input_used, [2] halted,
                              // [3] bracket_error, [4] append_full

    interp_scoreboard ledger;
    int               gap_pct;       // chance in percent that the sender pauses
    int               stall_pct;     // chance in percent that the receiver stalls
    bit               calm;          // set for the last part of the run: no idling at all
    int               items_sent;
    int               quiet_cycles;

    brainfuck_interpreter_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offers one item at a falling edge, sometimes after a random pause, and holds it until
    // the block takes it. The shadow model is updated at that edge.
    task automatic send_item(bfi_pkg::cmd_t cmd, logic [7:0] data);
        @(negedge clk);
        if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = data;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        // An execute on a halted machine does nothing, so it does not count as work.
        if (!(cmd == bfi_pkg::CMD_EXECUTE && ledger.halted()))
            items_sent++;
        ledger.apply_command(cmd, data);
    endtask

    task automatic load_program(char_q_t text);
        foreach (text[i])
            send_item(bfi_pkg::CMD_APPEND, text[i]);
    endtask

    // Holds the sender back until every reply owed by the block has come in. The last
    // item is withdrawn first so that the block cannot take it a second time.
    task automatic drain_replies();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (ledger.pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: ready by default, with random stall bursts.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    // Every accepted result item is checked against the oldest pending one.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            ledger.check_reply({m_tuser[0], m_tdata[7:0], m_tuser[1], m_tuser[2], m_tuser[3],
                                m_tuser[4], m_tdata[18:8]});
    end

    // Ends the run if neither side has moved an item for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        char_q_t    text;
        logic [7:0] c;
        int         len;
        int         budget;
        int         steps;
        int         pick;
        int         open_count;

        ledger       = new();
        quiet_cycles = 0;
        items_sent   = 0;
        gap_pct      = 0;
        stall_pct    = 0;
        calm         = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = bfi_pkg::CMD_APPEND;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. An execute on an empty program must report halted. The short
        // program then moves the pointer left from zero so that it wraps to the top of
        // the tape, takes that cell below zero, emits it, overwrites it from the input
        // byte, moves right again across the wrap, steps over a character that is not a
        // command, and ends on a closing bracket with no partner on a nonzero cell,
        // which must halt with a bracket error. One more execute hits the halted machine.
        send_item(bfi_pkg::CMD_EXECUTE, 8'hFF);
        load_program('{bfi_pkg::CH_LEFT, bfi_pkg::CH_DEC, bfi_pkg::CH_OUT, bfi_pkg::CH_IN,
                       bfi_pkg::CH_OUT, bfi_pkg::CH_RIGHT, bfi_pkg::CH_INC, bfi_pkg::CH_OUT,
                       8'hFF, bfi_pkg::CH_CLOSE});
        repeat (11) send_item(bfi_pkg::CMD_EXECUTE, 8'h00);
        send_item(bfi_pkg::CMD_RESTART, 8'h00);
        send_item(bfi_pkg::CMD_CLEAR_PROG, 8'hFF);

        // Fill the whole program store: an opening bracket, characters that are not
        // brackets, and the matching bracket in the very last entry. One more append must
        // be refused. On the freshly cleared tape the opening bracket then walks the full
        // store and leaves the program counter at the end of the store.
        gap_pct   = 10;
        stall_pct = 10;
        send_item(bfi_pkg::CMD_APPEND, bfi_pkg::CH_OPEN);
        repeat (bfi_pkg::PROGRAM_DEPTH - 2)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == bfi_pkg::CH_OPEN || c == bfi_pkg::CH_CLOSE);
            send_item(bfi_pkg::CMD_APPEND, c);
        end
        send_item(bfi_pkg::CMD_APPEND, bfi_pkg::CH_CLOSE);
        send_item(bfi_pkg::CMD_APPEND, 8'($urandom_range(0, 255)));
        send_item(bfi_pkg::CMD_EXECUTE, 8'($urandom_range(0, 255)));
        send_item(bfi_pkg::CMD_EXECUTE, 8'($urandom_range(0, 255)));
        drain_replies();

        // Random part: short well-formed programs with random content, run until they halt
        // or use up their step budget, with stray commands mixed in and now and then a
        // bracket left without a partner.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: gap_pct = 0;
                1: gap_pct = 5;
                2: gap_pct = 20;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 5;
                2: stall_pct = 20;
                default: stall_pct = 40;
            endcase
            calm = (items_sent > RANDOM_ITEMS * 4 / 5);

            if ($urandom_range(0, 2) == 0)
                send_item(bfi_pkg::CMD_RESTART, 8'($urandom_range(0, 255)));
            send_item(bfi_pkg::CMD_CLEAR_PROG, 8'($urandom_range(0, 255)));

            len        = $urandom_range(1, 40);
            open_count = 0;
            text.delete();
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 22)
                    text.push_back(bfi_pkg::CH_INC);
                else if (pick < 30)
                    text.push_back(bfi_pkg::CH_DEC);
                else if (pick < 40)
                    text.push_back(bfi_pkg::CH_RIGHT);
                else if (pick < 48)
                    text.push_back(bfi_pkg::CH_LEFT);
                else if (pick < 60)
                    text.push_back(bfi_pkg::CH_OUT);
                else if (pick < 68)
                    text.push_back(bfi_pkg::CH_IN);
                else if (pick < 80 && open_count < 4)
                begin
                    text.push_back(bfi_pkg::CH_OPEN);
                    open_count++;
                end
                else if (pick < 92 && open_count > 0)
                begin
                    text.push_back(bfi_pkg::CH_CLOSE);
                    open_count--;
                end
                else
                    text.push_back(8'($urandom_range(0, 255)));
            end
            repeat (open_count) text.push_back(bfi_pkg::CH_CLOSE);
            if ($urandom_range(0, 5) == 0)
                text.insert($urandom_range(0, text.size()),
                            $urandom_range(0, 1) ? bfi_pkg::CH_OPEN : bfi_pkg::CH_CLOSE);
            load_program(text);

            budget = $urandom_range(len, 4 * len + 8);
            steps  = 0;
            while (steps < budget && !ledger.halted())
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(bfi_pkg::cmd_t'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)));
                else
                    send_item(bfi_pkg::CMD_EXECUTE, 8'($urandom_range(0, 255)));
                steps++;
            end
            repeat ($urandom_range(0, 2))
                send_item(bfi_pkg::CMD_EXECUTE, 8'($urandom_range(0, 255)));

            if ($urandom_range(0, 4) == 0)
                drain_replies();
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        drain_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/bfi_pkg.sv
rtl/core/bfi_ctrl.sv
rtl/core/bfi_datapath.sv
rtl/core/brainfuck_interpreter_core.sv
sim/brainfuck_interpreter_core_tb.sv
